// ===== design/htq_pkg.sv =====
// Package for the heap timer queue: sequencer states, operation and status codes.
// No dependencies; used by the top level and the testbench.
`default_nettype none
package htq_pkg;

    localparam int ID_BITS  = 4;
    localparam int ID_COUNT = 16;
    localparam int CNT_BITS = 5;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CHECK  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_FULL       = 2'd1,
        ST_QUEUED     = 2'd2,
        ST_NOT_QUEUED = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_TK_START,
        S_TK_LOAD,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_PICK,
        S_DN_CMP,
        S_FIN,
        S_CK_RD,
        S_CK_CMP
    } t_state;

endpackage
`default_nettype wire

// ===== design/htq_cmp.sv =====
// Shared unsigned magnitude comparator for the heap timer queue.
// Depends on nothing but its parameter.
`default_nettype none
module htq_cmp #(
    parameter int TIME_BITS = 32
) (
    input  wire logic [TIME_BITS-1:0] i_a,
    input  wire logic [TIME_BITS-1:0] i_b,
    output logic                      o_lt,
    output logic                      o_le
);
    assign o_lt = i_a < i_b;
    assign o_le = i_a <= i_b;
endmodule
`default_nettype wire

// ===== design/htq_mem.sv =====
// Heap slot store: one write port and one registered read port.
// Depends on nothing but its parameters.
`default_nettype none
module htq_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 36
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== design/heap_timer_queue_top.sv =====
// Top level of the heap timer queue: sequencer, id tables and result register.
// Depends on htq_pkg, htq_cmp and htq_mem.
`default_nettype none
// A binary min-heap of timer expiry times driven by one command at a time. A command
// is taken when start is high and busy low; busy then stays high until the last result
// has been produced. Every result appears for one cycle with o_valid and cannot be
// stalled. Each heap level visited takes a read and a compare state on sift up, and a
// read of each child, a pick when there are two and a compare on sift down, because every heap slot comes
// through the single registered read port of the slot store and every key compare goes
// through the one shared comparator. A refused request keeps busy high only in the
// dispatch state. The last result of a command shows in the first cycle that busy is
// low; the fired timers of a check show before it, while busy is still high, and busy
// stays high over a check until every timer that is due has been removed.
module heap_timer_queue_top #(
    parameter int HEAP_DEPTH = 16,
    parameter int TIME_BITS  = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [3:0]  i_timer_id,
    input  wire logic [31:0] i_expire_time,
    input  wire logic [31:0] i_now_time,
    output logic             o_valid,
    output logic [1:0]       o_status,
    output logic             o_fired,
    output logic [3:0]       o_fired_id,
    output logic [4:0]       o_entry_count,
    output logic             o_last
);
    import htq_pkg::*;

    localparam int PW = $clog2(HEAP_DEPTH);
    localparam int SW = $clog2(HEAP_DEPTH + 1);
    localparam int KW = PW + 2;
    localparam int DW = TIME_BITS + ID_BITS;

    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic [ID_BITS-1:0]   r_id, n_id;
    logic [TIME_BITS-1:0] r_now, n_now;
    logic [DW-1:0]        r_cur, n_cur, r_kid, n_kid;
    logic [PW-1:0]        r_pos, n_pos, r_kidpos, n_kidpos;
    logic [SW-1:0]        r_size, n_size;
    logic [ID_COUNT-1:0]  r_queued, n_queued;
    logic [PW-1:0]        r_slot [ID_COUNT];
    logic                 r_rm, n_rm, r_moved, n_moved, r_pend, n_pend;
    logic [ID_BITS-1:0]   r_pend_id, n_pend_id;
    logic                 r_ov, n_ov, r_fr, n_fr, r_last, n_last;
    t_status              r_st, n_st;
    logic [ID_BITS-1:0]   r_fid, n_fid;
    logic [CNT_BITS-1:0]  r_cnt, n_cnt;

    logic                 mem_we;
    logic [PW-1:0]        mem_waddr, mem_raddr;
    logic [DW-1:0]        mem_wdata, mem_rdata;
    logic                 slot_we;
    logic [ID_BITS-1:0]   slot_wid;
    logic [PW-1:0]        slot_wpos;
    logic [TIME_BITS-1:0] cmp_a, cmp_b;
    logic                 cmp_lt, cmp_le;

    logic [KW-1:0] w_kid, w_kid1;
    logic          w_kid_in, w_kid1_in, w_full, w_q, w_fire;
    logic [PW-1:0] w_end, w_parent, w_slotpos;

    assign w_kid     = KW'({r_pos, 1'b1});
    assign w_kid1    = w_kid + KW'(1);
    assign w_kid_in  = w_kid < KW'(r_size);
    assign w_kid1_in = w_kid1 < KW'(r_size);
    assign w_end     = PW'(r_size - SW'(1));
    assign w_parent  = PW'((r_pos - PW'(1)) >> 1);
    assign w_full    = r_size >= SW'(HEAP_DEPTH);
    assign w_q       = r_queued[r_id];
    assign w_slotpos = r_slot[r_id];
    assign w_fire    = (r_size != '0) && cmp_le;

    htq_mem #(.DEPTH(HEAP_DEPTH), .WIDTH(DW)) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    htq_cmp #(.TIME_BITS(TIME_BITS)) u_cmp (
        .i_a (cmp_a),
        .i_b (cmp_b),
        .o_lt(cmp_lt),
        .o_le(cmp_le)
    );

    // Operand selection for the shared comparator.
    always_comb begin
        cmp_a = r_cur[DW-1:ID_BITS];
        cmp_b = mem_rdata[DW-1:ID_BITS];
        unique case (r_state)
            S_DN_PICK: begin
                cmp_a = r_kid[DW-1:ID_BITS];
            end
            S_DN_CMP: begin
                cmp_b = r_kid[DW-1:ID_BITS];
            end
            S_CK_CMP: begin
                cmp_a = mem_rdata[DW-1:ID_BITS];
                cmp_b = r_now;
            end
            default: begin
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (start) n_state = S_DISPATCH;
            S_DISPATCH: begin
                unique case (r_op)
                    OP_ADD:    n_state = (w_q || w_full) ? S_IDLE : S_UP_RD;
                    OP_REMOVE: n_state = w_q ? S_TK_START : S_IDLE;
                    OP_CHECK:  n_state = S_CK_RD;
                    default:   n_state = S_IDLE;
                endcase
            end
            S_TK_START: n_state = (w_slotpos == w_end) ? S_FIN : S_TK_LOAD;
            S_TK_LOAD:  n_state = S_UP_RD;
            S_UP_RD: begin
                if (r_pos != '0) n_state = S_UP_CMP;
                else n_state = (r_rm && !r_moved) ? S_DN_RDL : S_FIN;
            end
            S_UP_CMP: begin
                if (cmp_lt) n_state = S_UP_RD;
                else n_state = (r_rm && !r_moved) ? S_DN_RDL : S_FIN;
            end
            S_DN_RDL:   n_state = w_kid_in ? S_DN_RDR : S_FIN;
            S_DN_RDR:   n_state = w_kid1_in ? S_DN_PICK : S_DN_CMP;
            S_DN_PICK:  n_state = S_DN_CMP;
            S_DN_CMP:   n_state = cmp_le ? S_FIN : S_DN_RDL;
            S_FIN:      n_state = (r_op == OP_CHECK) ? S_CK_RD : S_IDLE;
            S_CK_RD:    n_state = S_CK_CMP;
            S_CK_CMP:   n_state = w_fire ? S_TK_START : S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Datapath, table writes and results.
    always_comb begin
        n_op = r_op;  n_id = r_id;  n_now = r_now;  n_cur = r_cur;  n_kid = r_kid;
        n_pos = r_pos;  n_kidpos = r_kidpos;  n_size = r_size;  n_queued = r_queued;
        n_rm = r_rm;  n_moved = r_moved;  n_pend = r_pend;  n_pend_id = r_pend_id;
        n_ov = 1'b0;  n_st = ST_OK;  n_fr = 1'b0;  n_fid = '0;  n_last = 1'b1;
        n_cnt = CNT_BITS'(r_size);
        mem_we = 1'b0;  mem_waddr = r_pos;  mem_wdata = r_cur;  mem_raddr = '0;
        slot_we = 1'b0;  slot_wid = r_cur[ID_BITS-1:0];  slot_wpos = r_pos;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op   = t_op'(i_opcode);
                    n_id   = i_timer_id;
                    n_now  = TIME_BITS'(i_now_time);
                    n_cur  = {TIME_BITS'(i_expire_time), i_timer_id};
                    n_pend = 1'b0;
                end
            end
            S_DISPATCH: begin
                unique case (r_op)
                    OP_ADD: begin
                        if (w_q) begin
                            n_ov = 1'b1;  n_st = ST_QUEUED;
                        end else if (w_full) begin
                            n_ov = 1'b1;  n_st = ST_FULL;
                        end else begin
                            n_pos = PW'(r_size);
                            n_size = r_size + SW'(1);
                            n_queued[r_id] = 1'b1;
                            n_rm = 1'b0;  n_moved = 1'b0;
                        end
                    end
                    OP_REMOVE: begin
                        if (!w_q) begin
                            n_ov = 1'b1;  n_st = ST_NOT_QUEUED;
                        end
                    end
                    OP_CHECK: begin
                    end
                    default: n_ov = 1'b1;
                endcase
            end
            S_TK_START: begin
                n_pos = w_slotpos;
                n_queued[r_id] = 1'b0;
                n_size = r_size - SW'(1);
                mem_raddr = w_end;
            end
            S_TK_LOAD: begin
                n_cur = mem_rdata;
                n_rm = 1'b1;  n_moved = 1'b0;
            end
            S_UP_RD: begin
                mem_raddr = w_parent;
                if (r_pos == '0 && !(r_rm && !r_moved)) begin
                    mem_we = 1'b1;  slot_we = 1'b1;
                end
            end
            S_UP_CMP: begin
                if (cmp_lt) begin
                    // The parent drops into the hole; the moving entry stays in r_cur.
                    mem_we = 1'b1;  mem_wdata = mem_rdata;
                    slot_we = 1'b1;  slot_wid = mem_rdata[ID_BITS-1:0];
                    n_pos = w_parent;  n_moved = 1'b1;
                end else if (!(r_rm && !r_moved)) begin
                    mem_we = 1'b1;  slot_we = 1'b1;
                end
            end
            S_DN_RDL: begin
                mem_raddr = PW'(w_kid);
                if (!w_kid_in) begin
                    mem_we = 1'b1;  slot_we = 1'b1;
                end
            end
            S_DN_RDR: begin
                n_kid = mem_rdata;  n_kidpos = PW'(w_kid);
                mem_raddr = PW'(w_kid1);
            end
            S_DN_PICK: begin
                // The right child wins unless the left one is strictly earlier.
                if (!cmp_lt) begin
                    n_kid = mem_rdata;  n_kidpos = PW'(w_kid1);
                end
            end
            S_DN_CMP: begin
                mem_we = 1'b1;  slot_we = 1'b1;
                if (!cmp_le) begin
                    mem_wdata = r_kid;  slot_wid = r_kid[ID_BITS-1:0];
                    n_pos = r_kidpos;
                end
            end
            S_FIN: begin
                if (r_op != OP_CHECK) n_ov = 1'b1;
            end
            S_CK_RD: begin
                mem_raddr = '0;
            end
            S_CK_CMP: begin
                // A fired timer is reported once the next root has been tested.
                if (r_pend) begin
                    n_ov = 1'b1;  n_fr = 1'b1;  n_fid = r_pend_id;  n_last = !w_fire;
                end else if (!w_fire) begin
                    n_ov = 1'b1;
                end
                if (w_fire) begin
                    n_id = mem_rdata[ID_BITS-1:0];
                    n_pend = 1'b1;  n_pend_id = mem_rdata[ID_BITS-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_size   <= '0;
            r_queued <= '0;
            r_ov     <= 1'b0;
            r_pend   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_size   <= n_size;
            r_queued <= n_queued;
            r_ov     <= n_ov;
            r_pend   <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op;  r_id <= n_id;  r_now <= n_now;  r_cur <= n_cur;  r_kid <= n_kid;
        r_pos <= n_pos;  r_kidpos <= n_kidpos;  r_rm <= n_rm;  r_moved <= n_moved;
        r_pend_id <= n_pend_id;  r_st <= n_st;  r_fr <= n_fr;  r_fid <= n_fid;
        r_last <= n_last;  r_cnt <= n_cnt;
        if (slot_we) begin
            r_slot[slot_wid] <= slot_wpos;
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_ov;
    assign o_status      = r_st;
    assign o_fired       = r_fr;
    assign o_fired_id    = r_fid;
    assign o_entry_count = r_cnt;
    assign o_last        = r_last;
endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for the heap timer queue: directed and random commands,
// with a heap predictor in a small scoreboard class. Depends on htq_pkg and the top.
`default_nettype none
module tb;
    import htq_pkg::*;

    localparam int DEPTH     = 16;
    localparam int N_RANDOM  = 370;
    localparam int CYC_LIMIT = 400000;

    typedef struct packed {
        logic [1:0] status;
        logic       fired;
        logic [3:0] fired_id;
        logic [4:0] entry_count;
        logic       last;
    } t_outcome;

    class timer_heap_board;
        logic [31:0] expiry [DEPTH];
        logic [3:0]  owner [DEPTH];
        logic [3:0]  slot [ID_COUNT];
        bit          queued [ID_COUNT];
        int          size;
        t_outcome    pending[$];
        int          errors;

        function new();
            size = 0;
            errors = 0;
            foreach (queued[i]) queued[i] = 0;
        endfunction

        function void swap_slots(int a, int b);
            logic [31:0] t;
            logic [3:0]  o;
            t = expiry[a]; o = owner[a];
            expiry[a] = expiry[b]; owner[a] = owner[b];
            expiry[b] = t; owner[b] = o;
            slot[owner[a]] = 4'(a);
            slot[owner[b]] = 4'(b);
        endfunction

        function void rise(int pos);
            while (pos > 0 && expiry[pos] < expiry[(pos - 1) / 2]) begin
                swap_slots(pos, (pos - 1) / 2);
                pos = (pos - 1) / 2;
            end
        endfunction

        function void sink(int pos);
            int kid;
            int pick;
            kid = pos * 2 + 1;
            while (kid < size) begin
                pick = (kid + 1 == size || expiry[kid] < expiry[kid + 1]) ? kid : kid + 1;
                if (expiry[pos] <= expiry[pick]) break;
                swap_slots(pos, pick);
                pos = pick;
                kid = pos * 2 + 1;
            end
        endfunction

        function void unlink(logic [3:0] id);
            int pos;
            pos = slot[id];
            queued[id] = 0;
            if (pos != size - 1) swap_slots(pos, size - 1);
            size--;
            if (pos < size) begin
                if (pos > 0 && expiry[pos] < expiry[(pos - 1) / 2]) rise(pos);
                else sink(pos);
            end
        endfunction

        function void push_outcome(t_status st, bit f, logic [3:0] fid, bit lst);
            t_outcome r;
            r.status = st; r.fired = f; r.fired_id = fid;
            r.entry_count = 5'(size); r.last = lst;
            pending = {pending, r};
        endfunction

        function void note_command(t_op op, logic [3:0] id, logic [31:0] exp_t,
                                   logic [31:0] now_t);
            int n;
            logic [3:0] who;
            n = 0;
            case (op)
                OP_ADD: begin
                    if (queued[id]) push_outcome(ST_QUEUED, 0, 0, 1);
                    else if (size >= DEPTH) push_outcome(ST_FULL, 0, 0, 1);
                    else begin
                        expiry[size] = exp_t; owner[size] = id;
                        slot[id] = 4'(size); queued[id] = 1;
                        size++;
                        rise(size - 1);
                        push_outcome(ST_OK, 0, 0, 1);
                    end
                end
                OP_REMOVE: begin
                    if (!queued[id]) push_outcome(ST_NOT_QUEUED, 0, 0, 1);
                    else begin
                        unlink(id);
                        push_outcome(ST_OK, 0, 0, 1);
                    end
                end
                OP_CHECK: begin
                    while (size > 0 && expiry[0] <= now_t && n < ID_COUNT) begin
                        who = owner[0];
                        unlink(who);
                        push_outcome(ST_OK, 1, who, 0);
                        n++;
                    end
                    if (n == 0) push_outcome(ST_OK, 0, 0, 1);
                    else pending[$].last = 1;
                end
                default: push_outcome(ST_OK, 0, 0, 1);
            endcase
        endfunction

        function void check_result(t_outcome got);
            t_outcome want;
            if (pending.size() == 0) begin
                $error("unexpected result %p", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status); errors++;
            end
            if (got.fired !== want.fired) begin
                $error("fired: expected %0d, got %0d", want.fired, got.fired); errors++;
            end
            if (got.fired_id !== want.fired_id) begin
                $error("fired_id: expected %0d, got %0d", want.fired_id, got.fired_id);
                errors++;
            end
            if (got.entry_count !== want.entry_count) begin
                $error("entry_count: expected %0d, got %0d", want.entry_count,
                       got.entry_count);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, got.last); errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        start = 0;
    logic        busy;
    logic [1:0]  i_opcode = 0;
    logic [3:0]  i_timer_id = 0;
    logic [31:0] i_expire_time = 0;
    logic [31:0] i_now_time = 0;
    logic        o_valid;
    logic [1:0]  o_status;
    logic        o_fired;
    logic [3:0]  o_fired_id;
    logic [4:0]  o_entry_count;
    logic        o_last;

    timer_heap_board board = new();
    int  cycles = 0;
    bit  calm = 0;
    logic [31:0] clock_ms = 0;

    heap_timer_queue_top #(.HEAP_DEPTH(DEPTH), .TIME_BITS(32)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_opcode(i_opcode), .i_timer_id(i_timer_id),
        .i_expire_time(i_expire_time), .i_now_time(i_now_time),
        .o_valid(o_valid), .o_status(o_status), .o_fired(o_fired),
        .o_fired_id(o_fired_id), .o_entry_count(o_entry_count), .o_last(o_last)
    );

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    always @(posedge i_clk) begin
        t_outcome r;
        cycles <= cycles + 1;
        if (i_rst_n && o_valid) begin
            r = '{o_status, o_fired, o_fired_id, o_entry_count, o_last};
            board.check_result(r);
        end
        if (cycles > CYC_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Presents one command and holds it until the transfer; start stays high
    // across back-to-back commands so it is never lowered and raised in one step.
    task automatic issue(t_op op, logic [3:0] id, logic [31:0] exp_t, logic [31:0] now_t);
        while (!calm && $urandom_range(99) < 34) begin
            start <= 0;
            @(posedge i_clk);
        end
        start <= 1;
        i_opcode <= op;
        i_timer_id <= id;
        i_expire_time <= exp_t;
        i_now_time <= now_t;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        board.note_command(op, id, exp_t, now_t);
    endtask

    initial begin
        int k;
        int drain;
        t_op op;
        logic [31:0] span;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: empty queue cases, extreme times, ties, duplicate adds, a filled queue, unused opcode.
        issue(OP_CHECK, 4'd0, 32'd0, 32'hFFFF_FFFF);
        issue(OP_REMOVE, 4'd15, 32'd0, 32'd0);
        issue(OP_NONE, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue(OP_ADD, 4'd0, 32'hFFFF_FFFF, 32'd0);
        issue(OP_ADD, 4'd0, 32'd5, 32'd0);
        issue(OP_ADD, 4'd15, 32'd0, 32'd0);
        for (k = 1; k < 15; k++) issue(OP_ADD, k[3:0], 32'd100, 32'd0);
        issue(OP_ADD, 4'd7, 32'd1, 32'd0);
        issue(OP_REMOVE, 4'd3, 32'd0, 32'd0);
        issue(OP_ADD, 4'd3, 32'd100, 32'd0);
        issue(OP_CHECK, 4'd0, 32'd0, 32'd99);
        issue(OP_CHECK, 4'd0, 32'd0, 32'd100);
        issue(OP_CHECK, 4'd0, 32'd0, 32'hFFFF_FFFF);

        // Random: mostly adds and removes of plausible ids around a moving clock,
        // with checks that fire part of the queue; a calm stretch in the middle.
        for (k = 0; k < N_RANDOM; k++) begin
            calm = (k >= 150 && k < 220);
            span = ($urandom_range(9) == 0) ? 32'hFFFF_FFFF : 32'd200;
            case ($urandom_range(9))
                0, 1, 2, 3: op = OP_ADD;
                4, 5:       op = OP_REMOVE;
                6, 7, 8:    op = OP_CHECK;
                default:    op = ($urandom_range(1)) ? OP_NONE : OP_ADD;
            endcase
            if (op == OP_CHECK) clock_ms = clock_ms + $urandom_range(60);
            issue(op, 4'($urandom_range(15)),
                  ($urandom_range(7) == 0) ? $urandom() : clock_ms + $urandom_range(span),
                  ($urandom_range(15) == 0) ? $urandom() : clock_ms);
        end
        start <= 0;

        drain = 0;
        while (board.pending.size() != 0 && drain < 2000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (80) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire
